// ----- rtl/bmpgw_pkg.sv -----
package bmpgw_pkg;

    // Image geometry.
    localparam int MaxDimension = 4096;
    localparam int DimBits      = $clog2(MaxDimension) + 1;
    localparam int CountBits    = $clog2(MaxDimension);
    localparam int RowBytesBits = DimBits + 2;

    // Pixel and byte formats.
    localparam int FractionBits = 12;
    localparam int ChanBits     = 16;
    localparam int ByteBits     = 8;
    localparam int ByteVals     = 1 << ByteBits;
    localparam int LaneStages   = ByteBits;
    localparam int ThrBits      = FractionBits + 1;

    // Gamma 1/2.2 written as the ratio 5/11.
    localparam int GammaValPow  = 5;
    localparam int GammaRootPow = 11;
    localparam int WideBits     = GammaValPow * (FractionBits + 1) + GammaRootPow * ByteBits;

    // Configuration port.
    localparam int CfgIndexBits = 1;
    localparam int CfgDataBits  = DimBits;

    // File header.
    localparam int HdrBytes      = 54;
    localparam int HdrCntBits    = $clog2(HdrBytes);
    localparam int FileSizeBits  = 32;
    localparam int InfoBytes     = 40;
    localparam int BitsPerPixel  = 24;
    localparam int PlanesVal     = 1;
    localparam int HdrSizeOfs    = 2;
    localparam int HdrOffsetOfs  = 10;
    localparam int HdrInfoOfs    = 14;
    localparam int HdrWidthOfs   = 18;
    localparam int HdrHeightOfs  = 22;
    localparam int HdrPlanesOfs  = 26;
    localparam int HdrBppOfs     = 28;
    localparam logic [ByteBits-1:0] CharB = 8'h42;
    localparam logic [ByteBits-1:0] CharM = 8'h4D;

    typedef enum logic [CfgIndexBits-1:0] {
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_BLUE,
        ST_GREEN,
        ST_RED,
        ST_PAD
    } t_ser_state;

    typedef struct packed {
        logic hdr;
        logic row_end;
        logic img_end;
    } t_pix_meta;

    typedef struct packed {
        t_pix_meta             meta;
        logic [ByteBits-1:0]   blue;
        logic [ByteBits-1:0]   green;
        logic [ByteBits-1:0]   red;
    } t_pix_rec;

    typedef logic [ThrBits-1:0] t_thr_table [ByteVals];

    // Entry b is the smallest linear value x (in 1/2^FractionBits units) whose encoded
    // byte reaches b, that is x^5 * 255^11 >= b^11 * 2^(5*FractionBits).
    function automatic t_thr_table gamma_thr_table();
        t_thr_table            tab;
        logic [WideBits-1:0]   scale;
        logic [WideBits-1:0]   goal;
        logic [WideBits-1:0]   lhs;
        int                    lo;
        int                    hi;
        int                    mid;
        scale = WideBits'(1);
        for (int i = 0; i < GammaRootPow; i++) begin
            scale = scale * WideBits'(ByteVals - 1);
        end
        tab[0] = '0;
        for (int b = 1; b < ByteVals; b++) begin
            goal = WideBits'(1);
            for (int i = 0; i < GammaRootPow; i++) begin
                goal = goal * WideBits'(b);
            end
            goal = goal << (GammaValPow * FractionBits);
            lo = 0;
            hi = 1 << FractionBits;
            for (int k = 0; k <= FractionBits; k++) begin
                if (lo < hi) begin
                    mid = (lo + hi) >> 1;
                    lhs = scale;
                    for (int i = 0; i < GammaValPow; i++) begin
                        lhs = lhs * WideBits'(mid);
                    end
                    if (lhs >= goal) begin
                        hi = mid;
                    end else begin
                        lo = mid + 1;
                    end
                end
            end
            tab[b] = ThrBits'(lo);
        end
        return tab;
    endfunction

    localparam t_thr_table GammaThr = gamma_thr_table();

endpackage

// ----- rtl/bmpgw_pix_if.sv -----
interface bmpgw_pix_if import bmpgw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ChanBits-1:0] red;
    logic [ChanBits-1:0] green;
    logic [ChanBits-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- rtl/bmpgw_byte_if.sv -----
interface bmpgw_byte_if import bmpgw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ByteBits-1:0] file_byte;
    logic                last_of_item;
    logic                end_of_image;

    modport source (output valid, output file_byte, output last_of_item,
                    output end_of_image, input ready);
    modport sink   (input valid, input file_byte, input last_of_item,
                    input end_of_image, output ready);
endinterface

// ----- rtl/bmpgw_lane.sv -----
// One gamma channel: a clamp stage, then one binary search step per output bit
// against the threshold table.
module bmpgw_lane import bmpgw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [ChanBits-1:0] i_x,
    output logic [ByteBits-1:0] o_byte
);

    logic [FractionBits-1:0] r_xl  [LaneStages+1];
    logic                    r_sat [LaneStages+1];
    logic [ByteBits-1:0]     r_b   [LaneStages+1];
    logic [ByteBits-1:0]     n_b   [LaneStages+1];

    always_comb begin
        logic [ByteBits-1:0] cand;
        n_b[0] = '0;
        for (int s = 1; s <= LaneStages; s++) begin
            cand = r_b[s-1] | (ByteBits'(1) << (LaneStages - s));
            if (GammaThr[cand] <= {1'b0, r_xl[s-1]}) begin
                n_b[s] = cand;
            end else begin
                n_b[s] = r_b[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xl[0]  <= i_x[FractionBits-1:0];
            r_sat[0] <= (i_x >> FractionBits) != '0;
            r_b[0]   <= n_b[0];
            for (int s = 1; s <= LaneStages; s++) begin
                r_xl[s]  <= r_xl[s-1];
                r_sat[s] <= r_sat[s-1];
                r_b[s]   <= n_b[s];
            end
        end
    end

    assign o_byte = r_sat[LaneStages] ? ByteBits'(ByteVals - 1) : r_b[LaneStages];

endmodule

// ----- rtl/bmpgw_serializer.sv -----
// Merges the three lane bytes of a pixel into the byte stream, with the file
// header in front of the first pixel and zero padding after each row.
module bmpgw_serializer import bmpgw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rec_valid,
    input  t_pix_rec              i_rec,
    output logic                  o_take,
    input  logic [DimBits-1:0]    i_width_eff,
    input  logic [DimBits-1:0]    i_height_eff,
    bmpgw_byte_if.source          o_out
);

    t_ser_state                 r_state;
    t_ser_state                 n_state;
    logic [HdrCntBits-1:0]      r_cnt;
    logic [HdrCntBits-1:0]      n_cnt;
    t_pix_rec                   r_rec;
    logic [FileSizeBits-1:0]    r_file_size;
    logic                       r_ov;
    logic [ByteBits-1:0]        r_obyte;
    logic                       r_olast;
    logic                       r_oeoi;

    logic [RowBytesBits-1:0]    row_bytes;
    logic [1:0]                 pad;
    logic                       can_emit;
    logic                       emit;
    logic                       fin;
    logic [ByteBits-1:0]        out_byte;

    function automatic logic [ByteBits-1:0] le_byte(input logic [FileSizeBits-1:0] v,
                                                    input logic [1:0] sel);
        return v[{sel, 3'b000} +: ByteBits];
    endfunction

    function automatic logic [ByteBits-1:0] hdr_byte(input logic [HdrCntBits-1:0] idx,
                                                     input logic [FileSizeBits-1:0] size,
                                                     input logic [DimBits-1:0] w,
                                                     input logic [DimBits-1:0] h);
        logic [ByteBits-1:0] b;
        b = '0;
        if (idx == HdrCntBits'(0)) begin
            b = CharB;
        end else if (idx == HdrCntBits'(1)) begin
            b = CharM;
        end else if (idx >= HdrCntBits'(HdrSizeOfs) && idx < HdrCntBits'(HdrSizeOfs + 4)) begin
            b = le_byte(size, 2'(idx - HdrCntBits'(HdrSizeOfs)));
        end else if (idx == HdrCntBits'(HdrOffsetOfs)) begin
            b = ByteBits'(HdrBytes);
        end else if (idx == HdrCntBits'(HdrInfoOfs)) begin
            b = ByteBits'(InfoBytes);
        end else if (idx >= HdrCntBits'(HdrWidthOfs) && idx < HdrCntBits'(HdrWidthOfs + 4)) begin
            b = le_byte(FileSizeBits'(w), 2'(idx - HdrCntBits'(HdrWidthOfs)));
        end else if (idx >= HdrCntBits'(HdrHeightOfs)
                     && idx < HdrCntBits'(HdrHeightOfs + 4)) begin
            b = le_byte(FileSizeBits'(h), 2'(idx - HdrCntBits'(HdrHeightOfs)));
        end else if (idx == HdrCntBits'(HdrPlanesOfs)) begin
            b = ByteBits'(PlanesVal);
        end else if (idx == HdrCntBits'(HdrBppOfs)) begin
            b = ByteBits'(BitsPerPixel);
        end
        return b;
    endfunction

    assign pad       = i_width_eff[1:0];
    assign row_bytes = RowBytesBits'(i_width_eff) * RowBytesBits'(3) + RowBytesBits'(pad);

    // The user keeps the configuration stable except while the block is idle; the
    // block does not enforce this, and the size is simply recomputed every cycle.
    always_ff @(posedge i_clk) begin
        r_file_size <= FileSizeBits'(HdrBytes)
                     + FileSizeBits'(row_bytes * FileSizeBits'(i_height_eff));
    end

    // Output side: what is shown, whether this is the pixel's last byte, and
    // whether the next record is taken.
    always_comb begin
        can_emit = !r_ov || o_out.ready;
        emit     = can_emit && (r_state != ST_IDLE);
        out_byte = '0;
        fin      = 1'b0;
        case (r_state)
            ST_HDR:   out_byte = hdr_byte(r_cnt, r_file_size, i_width_eff, i_height_eff);
            ST_BLUE:  out_byte = r_rec.blue;
            ST_GREEN: out_byte = r_rec.green;
            ST_RED: begin
                out_byte = r_rec.red;
                fin      = !r_rec.meta.row_end || (pad == 2'd0);
            end
            ST_PAD:   fin = (r_cnt + HdrCntBits'(1)) == HdrCntBits'(pad);
            default:  out_byte = '0;
        endcase
        o_take = i_rec_valid && ((r_state == ST_IDLE) || (emit && fin));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            ST_IDLE: begin
                if (o_take) begin
                    n_state = i_rec.meta.hdr ? ST_HDR : ST_BLUE;
                end
            end
            ST_HDR: begin
                if (emit && (r_cnt == HdrCntBits'(HdrBytes - 1))) begin
                    n_state = ST_BLUE;
                end
            end
            ST_BLUE: begin
                if (emit) begin
                    n_state = ST_GREEN;
                end
            end
            ST_GREEN: begin
                if (emit) begin
                    n_state = ST_RED;
                end
            end
            ST_RED, ST_PAD: begin
                if (emit) begin
                    if (!fin) begin
                        n_state = ST_PAD;
                    end else if (o_take) begin
                        n_state = i_rec.meta.hdr ? ST_HDR : ST_BLUE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (n_state != r_state) begin
            n_cnt = '0;
        end else if (emit && ((r_state == ST_HDR) || (r_state == ST_PAD))) begin
            n_cnt = r_cnt + HdrCntBits'(1);
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (can_emit) begin
                r_ov <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_rec <= i_rec;
        end
        if (can_emit) begin
            r_obyte <= out_byte;
            r_olast <= fin;
            r_oeoi  <= fin && r_rec.meta.img_end;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.file_byte    = r_obyte;
    assign o_out.last_of_item = r_olast;
    assign o_out.end_of_image = r_oeoi;

endmodule

// ----- rtl/bmp_rgb24_gamma_stream_writer_unit.sv -----
// Streaming writer for a 24-bit uncompressed BMP file.
//
// Channels: i_pix carries one linear RGB pixel per transfer (unsigned 4.12 per
// channel, pixels in row order); o_byte carries one file byte per transfer,
// with last_of_item on the final byte a pixel causes and end_of_image on the
// final byte of the file. Both use valid/ready; a transfer happens on a rising
// edge with valid and ready high. Image width and height are written through
// i_cfg_we/i_cfg_index/i_cfg_data, only while the block is idle, a rule
// for the user that the block itself does not enforce. A pixel passes the
// clamp register, which loads at the transfer edge, the eight search stages
// in the gamma lanes, the merge stage once it is free, and the output
// register. The output carries one byte per cycle while the receiver is
// ready: three bytes per pixel, plus the 54-byte header of each image and
// 1 to 3 bytes of padding at the end of rows whose width is not a multiple of
// four. The byte rate is the bound; lanes take a pixel per cycle unless held.
// Reset (synchronous, active low) empties the pipeline, returns both counters
// to the first pixel of a new file and sets width and height to 1.
// When the receiver stalls, the output byte holds; the lane pipeline keeps
// taking pixels until one sits in its last stage that the merge stage cannot
// take, then ready drops.
module bmp_rgb24_gamma_stream_writer_unit import bmpgw_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CfgIndexBits-1:0] i_cfg_index,
    input  logic [CfgDataBits-1:0]  i_cfg_data,
    bmpgw_pix_if.sink               i_pix,
    bmpgw_byte_if.source            o_byte
);

    logic [DimBits-1:0]   r_cfg_width;
    logic [DimBits-1:0]   r_cfg_height;
    logic [CountBits-1:0] r_col;
    logic [CountBits-1:0] r_row;
    logic                 r_v    [LaneStages+1];
    t_pix_meta            r_meta [LaneStages+1];

    logic [DimBits-1:0]   width_eff;
    logic [DimBits-1:0]   height_eff;
    logic                 en;
    logic                 accept;
    logic                 ser_take;
    t_pix_meta            meta;
    t_pix_rec             rec;
    logic [ByteBits-1:0]  lane_red;
    logic [ByteBits-1:0]  lane_green;
    logic [ByteBits-1:0]  lane_blue;

    // A zero dimension counts as 1 and anything beyond the maximum is clamped.
    function automatic logic [DimBits-1:0] dim_eff(input logic [DimBits-1:0] v);
        if (v == '0) begin
            return DimBits'(1);
        end else if (v > DimBits'(MaxDimension)) begin
            return DimBits'(MaxDimension);
        end
        return v;
    endfunction

    assign width_eff  = dim_eff(r_cfg_width);
    assign height_eff = dim_eff(r_cfg_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= DimBits'(1);
            r_cfg_height <= DimBits'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                default:          r_cfg_width  <= r_cfg_width;
            endcase
        end
    end

    // The whole lane pipeline advances together whenever its last stage is
    // empty or the merge stage takes the pixel there.
    assign en          = !r_v[LaneStages] || ser_take;
    assign i_pix.ready = en;
    assign accept      = i_pix.valid && en;

    // Position tracking: decided at transfer time and carried beside the lanes.
    always_comb begin
        meta.hdr     = (r_col == '0) && (r_row == '0);
        meta.row_end = ({1'b0, r_col} + DimBits'(1)) >= width_eff;
        meta.img_end = meta.row_end && (({1'b0, r_row} + DimBits'(1)) >= height_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            for (int s = 0; s <= LaneStages; s++) begin
                r_v[s] <= 1'b0;
            end
        end else begin
            if (accept) begin
                if (meta.row_end) begin
                    r_col <= '0;
                    r_row <= meta.img_end ? '0 : r_row + CountBits'(1);
                end else begin
                    r_col <= r_col + CountBits'(1);
                end
            end
            if (en) begin
                r_v[0] <= i_pix.valid;
                for (int s = 1; s <= LaneStages; s++) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_meta[0] <= meta;
            for (int s = 1; s <= LaneStages; s++) begin
                r_meta[s] <= r_meta[s-1];
            end
        end
    end

    bmpgw_lane u_lane_red (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (i_pix.red),
        .o_byte (lane_red)
    );

    bmpgw_lane u_lane_green (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (i_pix.green),
        .o_byte (lane_green)
    );

    bmpgw_lane u_lane_blue (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (i_pix.blue),
        .o_byte (lane_blue)
    );

    always_comb begin
        rec.meta  = r_meta[LaneStages];
        rec.blue  = lane_blue;
        rec.green = lane_green;
        rec.red   = lane_red;
    end

    bmpgw_serializer u_serializer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec_valid  (r_v[LaneStages]),
        .i_rec        (rec),
        .o_take       (ser_take),
        .i_width_eff  (width_eff),
        .i_height_eff (height_eff),
        .o_out        (o_byte)
    );

endmodule

// ----- rtl/bmpgw_checker.sv -----
module bmpgw_checker import bmpgw_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [ByteBits-1:0] i_out_byte,
    input logic                i_out_last,
    input logic                i_out_eoi
);

    logic       r_expect_hdr;
    logic [7:0] r_pend;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    // Pixels taken whose last byte has not gone out yet, and whether the next
    // byte must open a new file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_hdr <= 1'b1;
            r_pend       <= '0;
        end else begin
            if (out_xfer) begin
                r_expect_hdr <= i_out_last && i_out_eoi;
            end
            r_pend <= r_pend + 8'(in_xfer) - 8'(out_xfer && i_out_last);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_last) && $stable(i_out_eoi))
        else $error("output byte changed while stalled");

    a_eoi_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_eoi |-> i_out_last)
        else $error("end of image on a byte that does not close its pixel");

    a_file_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_expect_hdr |-> i_out_byte == CharB)
        else $error("file does not start with the header");

    a_last_has_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && i_out_last |-> r_pend != '0)
        else $error("pixel closed without a pixel taken");

endmodule

bind bmp_rgb24_gamma_stream_writer_unit bmpgw_checker u_bmpgw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_byte.valid),
    .i_out_ready (o_byte.ready),
    .i_out_byte  (o_byte.file_byte),
    .i_out_last  (o_byte.last_of_item),
    .i_out_eoi   (o_byte.end_of_image)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import bmpgw_pkg::*;

    // Run shape. Each side idles in roughly IdlePercent cycles of a hundred,
    // except in the steady phases of the random part.
    localparam int ResetCycles   = 5;
    localparam int IdlePercent   = 32;
    localparam int RandomPixels  = 136;
    // Quiet cycles after the last expected byte before a register write.
    localparam int SettleCycles  = 16;
    localparam int TailCycles    = 32;
    // Cycles without any transfer or register write before the run is abandoned.
    localparam int WatchdogLimit = 2000;
    localparam int MaxReports    = 40;

    typedef enum logic [1:0] {
        OPK_PIXEL,
        OPK_SETTING,
        OPK_HOLD
    } t_stim_kind;

    // One entry of the stimulus plan: a pixel, a register write, or a pause
    // until every expected byte has come out.
    typedef struct packed {
        t_stim_kind             kind;
        logic [ChanBits-1:0]    red;
        logic [ChanBits-1:0]    green;
        logic [ChanBits-1:0]    blue;
        t_cfg_reg               reg_sel;
        logic [CfgDataBits-1:0] value;
        logic                   steady;
    } t_stim_op;

    typedef struct packed {
        logic [ByteBits-1:0] data;
        logic                last_of_item;
        logic                end_of_image;
    } t_file_byte;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we;
    logic [CfgIndexBits-1:0] cfg_index;
    logic [CfgDataBits-1:0]  cfg_data;
    logic                    steady_now;

    bmpgw_pix_if  pix_ch ();
    bmpgw_byte_if byte_ch ();

    t_stim_op   stim_plan[$];
    t_file_byte file_bytes[$];

    // Shadow of the block: registers as written and the position of the next pixel.
    logic [CfgDataBits-1:0]  model_width;
    logic [CfgDataBits-1:0]  model_height;
    logic [CountBits-1:0]    col_at;
    logic [CountBits-1:0]    row_at;

    int settle;
    int idle_cycles;
    int pixels_taken;
    int bytes_checked;
    int images_seen;
    int cfg_writes;
    int mismatches;

    bmp_rgb24_gamma_stream_writer_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pix       (pix_ch.sink),
        .o_byte      (byte_ch.source)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Gamma encoding done exactly: the largest code c with
    // c^11 * 2^(5*FractionBits) <= x^5 * 255^11, found by bisection.
    // Anything at or above 1.0 saturates to full scale.
    function automatic logic [ByteBits-1:0] gamma_code(logic [ChanBits-1:0] level);
        logic [159:0] budget;
        logic [159:0] trial;
        int           lo;
        int           hi;
        int           mid;
        if (level >= ChanBits'(1 << FractionBits)) begin
            return ByteBits'(ByteVals - 1);
        end
        budget = 160'd1;
        for (int i = 0; i < GammaRootPow; i++) begin
            budget = budget * 160'(ByteVals - 1);
        end
        for (int i = 0; i < GammaValPow; i++) begin
            budget = budget * 160'(level);
        end
        lo = 0;
        hi = ByteVals - 1;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            trial = 160'd1;
            for (int i = 0; i < GammaRootPow; i++) begin
                trial = trial * 160'(mid);
            end
            trial = trial << (GammaValPow * FractionBits);
            if (trial <= budget) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return ByteBits'(lo);
    endfunction

    // A register value of zero acts as one, and anything above the maximum
    // dimension acts as the maximum.
    function automatic int unsigned dim_in_force(logic [CfgDataBits-1:0] raw);
        if (raw == 0) begin
            return 1;
        end
        if (raw > CfgDataBits'(MaxDimension)) begin
            return MaxDimension;
        end
        return 32'(raw);
    endfunction

    task automatic push_le(logic [31:0] val, int nbytes);
        t_file_byte fb;
        for (int i = 0; i < nbytes; i++) begin
            fb = '0;
            fb.data = val[8*i +: 8];
            file_bytes.push_back(fb);
        end
    endtask

    // Appends every file byte that one accepted pixel causes: the header when
    // the pixel opens a file, the three codes in B, G, R order, and the row
    // padding when it closes a row. The flags go on the final byte only.
    task automatic predict_pixel(logic [ChanBits-1:0] red, logic [ChanBits-1:0] green,
                                 logic [ChanBits-1:0] blue);
        int unsigned wid;
        int unsigned hgt;
        int unsigned pad;
        logic        at_end;
        t_file_byte  tail;
        wid = dim_in_force(model_width);
        hgt = dim_in_force(model_height);
        pad = wid % 4;
        at_end = 1'b0;
        if (col_at == 0 && row_at == 0) begin
            push_le(32'(CharB), 1);
            push_le(32'(CharM), 1);
            push_le(HdrBytes + (3 * wid + pad) * hgt, 4);
            push_le(0, 4);
            push_le(HdrBytes, 4);
            push_le(InfoBytes, 4);
            push_le(wid, 4);
            push_le(hgt, 4);
            push_le(PlanesVal, 2);
            push_le(BitsPerPixel, 2);
            // Compression, image size, both resolutions and the two color counts.
            for (int i = 0; i < 6; i++) begin
                push_le(0, 4);
            end
        end
        push_le(32'(gamma_code(blue)), 1);
        push_le(32'(gamma_code(green)), 1);
        push_le(32'(gamma_code(red)), 1);
        // Row and image ends follow the sizes in force now, so a register that
        // changed in the middle of an image takes effect at once.
        if (col_at + 1 >= wid) begin
            for (int i = 0; i < pad; i++) begin
                push_le(0, 1);
            end
            col_at = '0;
            if (row_at + 1 >= hgt) begin
                at_end = 1'b1;
                row_at = '0;
            end else begin
                row_at = row_at + CountBits'(1);
            end
        end else begin
            col_at = col_at + CountBits'(1);
        end
        tail = file_bytes.pop_back();
        tail.last_of_item = 1'b1;
        tail.end_of_image = at_end;
        file_bytes.push_back(tail);
    endtask

    function automatic void check_field(string field, logic [ByteBits-1:0] want,
                                        logic [ByteBits-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        end
    endfunction

    task automatic add_pixel(logic [ChanBits-1:0] red, logic [ChanBits-1:0] green,
                             logic [ChanBits-1:0] blue, logic steady);
        t_stim_op op;
        op = '0;
        op.kind = OPK_PIXEL;
        op.red = red;
        op.green = green;
        op.blue = blue;
        op.steady = steady;
        stim_plan.push_back(op);
    endtask

    task automatic add_setting(t_cfg_reg sel, logic [CfgDataBits-1:0] val);
        t_stim_op op;
        op = '0;
        op.kind = OPK_SETTING;
        op.reg_sel = sel;
        op.value = val;
        stim_plan.push_back(op);
    endtask

    // Channel levels lean toward the range below 1.0, where the curve is
    // interesting, with some full-range values so that every bit toggles and
    // some values right around 1.0.
    function automatic logic [ChanBits-1:0] random_level();
        case ($urandom_range(9)) inside
            [0:3]:   return ChanBits'($urandom_range((1 << FractionBits) - 1));
            [4:5]:   return ChanBits'($urandom);
            6:       return ChanBits'($urandom_range(63));
            7:       return ChanBits'((1 << FractionBits) - $urandom_range(8));
            default: return ChanBits'($urandom_range(1 << FractionBits,
                                                     1 << (FractionBits + 1)));
        endcase
    endfunction

    // Pixel and register driver. It works through the plan in order; a
    // register write or a pause waits until all expected bytes are out and
    // the pipeline has had time to drain. Outside reset, every driven signal gets
    // exactly one nonblocking assignment per edge.
    always @(posedge clk) begin : plan_driver
        logic                   go_valid;
        logic                   go_we;
        logic [CfgIndexBits-1:0] go_index;
        logic [CfgDataBits-1:0] go_data;
        logic [ChanBits-1:0]    go_red;
        logic [ChanBits-1:0]    go_green;
        logic [ChanBits-1:0]    go_blue;
        t_stim_op               head;
        if (!rst_n) begin
            pix_ch.valid <= 1'b0;
            cfg_we <= 1'b0;
            steady_now <= 1'b0;
            model_width = CfgDataBits'(1);
            model_height = CfgDataBits'(1);
            col_at = '0;
            row_at = '0;
            settle = 0;
        end else begin
            go_valid = pix_ch.valid;
            go_we = 1'b0;
            go_index = cfg_index;
            go_data = cfg_data;
            go_red = pix_ch.red;
            go_green = pix_ch.green;
            go_blue = pix_ch.blue;

            if (pix_ch.valid && pix_ch.ready) begin
                predict_pixel(pix_ch.red, pix_ch.green, pix_ch.blue);
                void'(stim_plan.pop_front());
                pixels_taken++;
                go_valid = 1'b0;
                settle = 0;
            end else if (file_bytes.size() != 0) begin
                settle = 0;
            end else if (settle < SettleCycles) begin
                settle++;
            end

            // Only one plan entry starts per cycle, so a pixel never starts
            // on the same edge as a register write.
            if (!go_valid && stim_plan.size() != 0) begin
                head = stim_plan[0];
                case (head.kind)
                    OPK_PIXEL: begin
                        if (head.steady || $urandom_range(99) >= IdlePercent) begin
                            go_valid = 1'b1;
                            go_red = head.red;
                            go_green = head.green;
                            go_blue = head.blue;
                        end
                    end
                    OPK_SETTING: begin
                        if (settle >= SettleCycles) begin
                            go_we = 1'b1;
                            go_index = head.reg_sel;
                            go_data = head.value;
                            if (head.reg_sel == CFG_IMAGE_WIDTH) begin
                                model_width = head.value;
                            end else begin
                                model_height = head.value;
                            end
                            cfg_writes++;
                            void'(stim_plan.pop_front());
                        end
                    end
                    default: begin
                        if (settle >= SettleCycles) begin
                            void'(stim_plan.pop_front());
                        end
                    end
                endcase
            end

            pix_ch.valid <= go_valid;
            pix_ch.red <= go_red;
            pix_ch.green <= go_green;
            pix_ch.blue <= go_blue;
            cfg_we <= go_we;
            cfg_index <= go_index;
            cfg_data <= go_data;
            steady_now <= (stim_plan.size() != 0) ? stim_plan[0].steady : 1'b0;
        end
    end

    // Byte monitor: each transfer on the output is matched against the oldest
    // expected byte, field by field. Ready is withheld at random except while
    // the sender is in a steady stretch.
    always @(posedge clk) begin : byte_monitor
        t_file_byte want;
        if (!rst_n) begin
            byte_ch.ready <= 1'b0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                bytes_checked++;
                if (byte_ch.end_of_image === 1'b1) begin
                    images_seen++;
                end
                if (file_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MaxReports) begin
                        $display("%0t: unexpected byte, expected none, actual %0h", $time,
                                 byte_ch.file_byte);
                    end
                end else begin
                    want = file_bytes.pop_front();
                    check_field("file_byte", want.data, byte_ch.file_byte);
                    check_field("last_of_item", ByteBits'(want.last_of_item),
                                ByteBits'(byte_ch.last_of_item));
                    check_field("end_of_image", ByteBits'(want.end_of_image),
                                ByteBits'(byte_ch.end_of_image));
                end
            end
            byte_ch.ready <= steady_now || ($urandom_range(99) >= IdlePercent);
        end
    end

    // Watchdog: counts cycles in which nothing moves at all.
    always @(posedge clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (byte_ch.valid && byte_ch.ready) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("%0t: no transfer for %0d cycles, %0d bytes still expected", $time,
                     idle_cycles, file_bytes.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        int                     rand_pixels;
        int                     phase;
        int                     count;
        logic                   steady;
        logic                   partial;
        logic [CfgDataBits-1:0] wv;
        logic [CfgDataBits-1:0] hv;
        t_stim_op               hold_op;

        pix_ch.valid = 1'b0;
        pix_ch.red = '0;
        pix_ch.green = '0;
        pix_ch.blue = '0;
        byte_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data = '0;
        steady_now = 1'b0;
        idle_cycles = 0;
        pixels_taken = 0;
        bytes_checked = 0;
        images_seen = 0;
        cfg_writes = 0;
        mismatches = 0;
        hold_op = '0;
        hold_op.kind = OPK_HOLD;

        // Directed part. With the reset size of 1 x 1 every pixel is a whole
        // file: black, all bits set, exactly 1.0 with its neighbors, tiny
        // values, and a few points along the curve.
        add_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        add_pixel(16'h1000, 16'h0FFF, 16'h1001, 1'b0);
        add_pixel(16'h0001, 16'h0002, 16'h0003, 1'b0);
        add_pixel(16'h8000, 16'h1000, 16'h0FFF, 1'b0);
        add_pixel(16'h0800, 16'h0400, 16'h0064, 1'b0);
        // Zero sizes act as one.
        add_setting(CFG_IMAGE_WIDTH, '0);
        add_setting(CFG_IMAGE_HEIGHT, '0);
        add_pixel(16'h0AAA, 16'h0555, 16'hFFFF, 1'b0);
        // Sizes beyond the maximum clamp to it; only the header and the
        // start of the first row are sent.
        add_setting(CFG_IMAGE_WIDTH, '1);
        add_setting(CFG_IMAGE_HEIGHT, '1);
        add_pixel(16'h5555, 16'hAAAA, 16'h0000, 1'b0);
        add_pixel(16'h0F00, 16'h00F0, 16'h000F, 1'b0);
        // The exact maximum, then back to 1 x 1, which closes the open image
        // at its next pixel.
        add_setting(CFG_IMAGE_WIDTH, CfgDataBits'(MaxDimension));
        add_setting(CFG_IMAGE_HEIGHT, CfgDataBits'(MaxDimension));
        add_pixel(16'h0123, 16'h0456, 16'h0789, 1'b0);
        add_setting(CFG_IMAGE_WIDTH, CfgDataBits'(1));
        add_setting(CFG_IMAGE_HEIGHT, CfgDataBits'(1));
        add_pixel(16'h0FFE, 16'h0002, 16'h0800, 1'b0);
        // Width narrowed in the middle of a row, then height lowered in the
        // middle of the image.
        add_setting(CFG_IMAGE_WIDTH, CfgDataBits'(5));
        add_setting(CFG_IMAGE_HEIGHT, CfgDataBits'(2));
        add_pixel(16'h0100, 16'h0200, 16'h0300, 1'b0);
        add_pixel(16'h0400, 16'h0500, 16'h0600, 1'b0);
        add_setting(CFG_IMAGE_WIDTH, CfgDataBits'(2));
        add_pixel(16'h0700, 16'h0800, 16'h0900, 1'b0);
        add_setting(CFG_IMAGE_HEIGHT, CfgDataBits'(1));
        add_pixel(16'h0A00, 16'h0B00, 16'h0C00, 1'b0);
        add_pixel(16'h0D00, 16'h0E00, 16'h0F00, 1'b0);
        // Three bytes of padding, then none.
        add_setting(CFG_IMAGE_WIDTH, CfgDataBits'(3));
        for (int i = 0; i < 3; i++) begin
            add_pixel(random_level(), random_level(), random_level(), 1'b0);
        end
        add_setting(CFG_IMAGE_WIDTH, CfgDataBits'(4));
        for (int i = 0; i < 4; i++) begin
            add_pixel(random_level(), random_level(), random_level(), 1'b0);
        end

        // Random part: mostly whole small images with random content. Now
        // and then an out-of-range size leaves an image open, which a switch
        // back to 1 x 1 then closes. A few phases run without any idling.
        rand_pixels = 0;
        phase = 0;
        while (rand_pixels < RandomPixels) begin
            steady = (phase >= 4 && phase < 8);
            partial = 1'b0;
            case ($urandom_range(7))
                0: begin
                    wv = $urandom_range(1) ? '0
                        : CfgDataBits'($urandom_range(MaxDimension, (1 << CfgDataBits) - 1));
                    hv = CfgDataBits'($urandom_range(1, 3));
                    partial = (wv != 0);
                end
                1: begin
                    wv = CfgDataBits'($urandom_range(1, 8));
                    hv = $urandom_range(1) ? '0
                        : CfgDataBits'($urandom_range(MaxDimension + 1, (1 << CfgDataBits) - 1));
                    partial = (hv != 0);
                end
                default: begin
                    wv = CfgDataBits'($urandom_range(1, 8));
                    hv = CfgDataBits'($urandom_range(1, 3));
                end
            endcase
            add_setting(CFG_IMAGE_WIDTH, wv);
            add_setting(CFG_IMAGE_HEIGHT, hv);
            count = partial ? $urandom_range(2, 6) : dim_in_force(wv) * dim_in_force(hv);
            for (int k = 0; k < count; k++) begin
                // Occasionally the sender stops in mid image until the
                // output has caught up completely.
                if (phase % 5 == 2 && k == count / 2) begin
                    stim_plan.push_back(hold_op);
                end
                add_pixel(random_level(), random_level(), random_level(), steady);
            end
            if (partial) begin
                add_setting(CFG_IMAGE_WIDTH, CfgDataBits'(1));
                add_setting(CFG_IMAGE_HEIGHT, CfgDataBits'(1));
                add_pixel(random_level(), random_level(), random_level(), steady);
                count++;
            end
            rand_pixels += count;
            phase++;
        end

        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_plan.size() != 0 || file_bytes.size() != 0) begin
            @(posedge clk);
        end
        repeat (TailCycles) @(posedge clk);

        $display("Covered %0d pixels and %0d register writes over %0d random phases.",
                 pixels_taken, cfg_writes, phase);
        $display("Checked %0d file bytes closing %0d images, %0d mismatches.",
                 bytes_checked, images_seen, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- bmp_rgb24_gamma_stream_writer_unit.f -----
rtl/bmpgw_pkg.sv
rtl/bmpgw_pix_if.sv
rtl/bmpgw_byte_if.sv
rtl/bmpgw_lane.sv
rtl/bmpgw_serializer.sv
rtl/bmp_rgb24_gamma_stream_writer_unit.sv
rtl/bmpgw_checker.sv
tb/testbench.sv
